/* hw/rtl/blpc_pkg.sv */
`default_nettype none

package blpc_pkg;

    localparam int MASK_W      = 12;
    localparam int LEVEL_W     = 8;
    localparam int DUTY_W      = 7;
    localparam int PHASE_W     = 6;
    localparam int WPHASE_W    = 3;
    localparam int WDUTY_W     = 4;
    localparam int WINDOW_W    = 16;
    localparam int CMD_W       = 3;
    localparam int INDEX_W     = 4;
    localparam int MODE_W      = 2;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = 3;

    localparam logic [LEVEL_W-1:0]  STATIC_RST   = 8'd80;
    localparam logic                REACTIVE_RST = 1'b1;
    localparam logic [LEVEL_W-1:0]  RELEASED_RST = 8'd80;
    localparam logic [LEVEL_W-1:0]  PRESSED_RST  = 8'd255;
    localparam logic [WINDOW_W-1:0] WINDOW_RST   = 16'd1500;

    typedef enum logic [CMD_W-1:0] {
        CMD_CTRL_TICK = 3'd0,
        CMD_PWM_TICK  = 3'd1,
        CMD_HOST_WR   = 3'd2,
        CMD_HOST_ON   = 3'd3,
        CMD_HOST_OFF  = 3'd4,
        CMD_SET_MODE  = 3'd5,
        CMD_TAKE_FLAG = 3'd6
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL = 2'd0,
        MODE_DIM    = 2'd1,
        MODE_OFF    = 2'd2
    } t_mode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_STATIC   = 3'd0,
        REG_REACTIVE = 3'd1,
        REG_RELEASED = 3'd2,
        REG_PRESSED  = 3'd3,
        REG_WINDOW   = 3'd4
    } t_reg_idx;

endpackage

`default_nettype wire

/* hw/rtl/blpc_in_if.sv */
`default_nettype none

interface blpc_in_if;
    logic                              valid;
    logic                              ready;
    logic [blpc_pkg::CMD_W-1:0]        cmd;
    logic [blpc_pkg::MASK_W-1:0]       buttons_held;
    logic [blpc_pkg::MASK_W-1:0]       buttons_pressed;
    logic [blpc_pkg::INDEX_W-1:0]      lamp_index;
    logic [blpc_pkg::LEVEL_W-1:0]      host_level;
    logic [blpc_pkg::MODE_W-1:0]       mode_req;

    modport source (
        output valid, cmd, buttons_held, buttons_pressed, lamp_index, host_level, mode_req,
        input  ready
    );
    modport sink (
        input  valid, cmd, buttons_held, buttons_pressed, lamp_index, host_level, mode_req,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/blpc_out_if.sv */
`default_nettype none

interface blpc_out_if;
    logic                              valid;
    logic                              ready;
    logic [blpc_pkg::MASK_W-1:0]       lamp_mask;
    logic [blpc_pkg::MODE_W-1:0]       light_mode;
    logic                              mode_flag;

    modport source (
        output valid, lamp_mask, light_mode, mode_flag,
        input  ready
    );
    modport sink (
        input  valid, lamp_mask, light_mode, mode_flag,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/button_lamp_pwm_controller.sv */
// Button lamp PWM controller. Every item is one command (control tick, PWM tick, host level
// write, host on/off, set mode, take flag) and yields exactly one result item carrying the
// lamp mask, the current mode and the mode-changed flag. All lamps are evaluated in parallel
// in one pass of logic, so an item is taken every cycle and its result appears in the output
// register in the cycle after acceptance; the only stall is a result not taken downstream.
// Settings are written over the APB port (register i at byte address 4*i); the user must
// write only while no item is in flight (not enforced); any settings write drops host control.
`default_nettype none

module button_lamp_pwm_controller #(
    parameter int LAMP_COUNT     = 12,
    parameter int WAD_LEFT_POS   = 8,
    parameter int WAD_RIGHT_POS  = 9,
    parameter int TEST_POS       = 10,
    parameter int SERVICE_POS    = 11,
    parameter int DIRECT_TOP_POS = 7
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    blpc_in_if.sink                              i_item,
    blpc_out_if.source                           o_result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [blpc_pkg::APB_AW-1:0]     paddr,
    input  wire logic [blpc_pkg::APB_DW-1:0]     pwdata,
    output logic      [blpc_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready
);

    localparam int MW = blpc_pkg::MASK_W;
    localparam int LW = blpc_pkg::LEVEL_W;
    localparam int DW = blpc_pkg::DUTY_W;
    localparam int PW = blpc_pkg::PHASE_W;
    localparam int QW = blpc_pkg::WPHASE_W;
    localparam int WD = blpc_pkg::WDUTY_W;
    localparam int CW = blpc_pkg::WINDOW_W;

    // settings
    logic [LW-1:0] r_static;
    logic          r_reactive;
    logic [LW-1:0] r_released;
    logic [LW-1:0] r_pressed;
    logic [CW-1:0] r_window_cfg;

    // state
    blpc_pkg::t_mode r_mode, n_mode;
    logic [PW-1:0]   r_phase, n_phase;
    logic [DW-1:0]   r_target [LAMP_COUNT];
    logic [DW-1:0]   n_target [LAMP_COUNT];
    logic [DW-1:0]   r_latched [LAMP_COUNT];
    logic [DW-1:0]   n_latched [LAMP_COUNT];
    logic [LW-1:0]   r_host [LAMP_COUNT];
    logic [LW-1:0]   n_host [LAMP_COUNT];
    logic [WD-1:0]   r_wad_l, n_wad_l;
    logic [WD-1:0]   r_wad_r, n_wad_r;
    logic            r_host_act, n_host_act;
    logic [CW-1:0]   r_window, n_window;
    logic            r_changed, n_changed;
    logic [MW-1:0]   r_mask, n_mask;

    // result register
    logic                  r_out_valid;
    logic [MW-1:0]         r_out_mask;
    blpc_pkg::t_mode       r_out_mode;
    logic                  r_out_flag;

    logic            accept;
    blpc_pkg::t_cmd  cmd;
    logic [15:0]     held_ext;
    logic [15:0]     pressed_ext;
    logic            test_hit;
    logic            service_hit;
    logic [CW-1:0]   sc_count;
    blpc_pkg::t_mode sc_mode;
    blpc_pkg::t_mode mode_adv;
    logic            sc_flag;
    logic [DW-1:0]   ctrl_tgt [LAMP_COUNT];
    logic [DW-1:0]   pwm_latched [LAMP_COUNT];
    logic [15:0]     lamp_hit;
    logic [DW-1:0]   wl_tgt, wr_tgt;
    logic [7:0]      wl_sum, wr_sum;
    logic [QW-1:0]   wphase;
    logic [WD-1:0]   pwm_wl, pwm_wr;
    logic            wl_on, wr_on;
    logic [MW-1:0]   pwm_mask;
    logic            cfg_wr;
    logic            cfg_hit;
    logic [blpc_pkg::REG_IDX_W-1:0] cfg_idx;

    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign cmd          = blpc_pkg::t_cmd'(i_item.cmd);
    assign held_ext     = {4'b0, i_item.buttons_held};
    assign pressed_ext  = {4'b0, i_item.buttons_pressed};
    assign test_hit     = pressed_ext[4'(TEST_POS)];
    assign service_hit  = pressed_ext[4'(SERVICE_POS)];

    // shortcut window
    always_comb begin
        unique case (r_mode)
            blpc_pkg::MODE_NORMAL: mode_adv = blpc_pkg::MODE_DIM;
            blpc_pkg::MODE_DIM:    mode_adv = blpc_pkg::MODE_OFF;
            default:               mode_adv = blpc_pkg::MODE_NORMAL;
        endcase
    end

    always_comb begin
        sc_count = test_hit ? r_window_cfg : r_window;
        sc_mode  = r_mode;
        sc_flag  = r_changed;
        if (service_hit && sc_count != '0) begin
            sc_mode  = mode_adv;
            sc_flag  = 1'b1;
            sc_count = '0;
        end else if (sc_count != '0) begin
            sc_count = sc_count - 1'b1;
        end
    end

    // per-lamp level, scaling and PWM compare
    for (genvar g = 0; g < LAMP_COUNT; g++) begin : g_lamp
        logic [LW-1:0] raw;
        logic [LW:0]   sum;
        logic [DW-1:0] req;

        always_comb begin
            if (g == WAD_LEFT_POS || g == WAD_RIGHT_POS) begin
                raw = held_ext[g] ? r_pressed : r_released;
            end else if (r_host_act && g <= DIRECT_TOP_POS) begin
                raw = r_host[g];
            end else if (r_reactive) begin
                raw = held_ext[g] ? r_pressed : r_released;
            end else begin
                raw = r_static;
            end
        end

        assign sum = {1'b0, raw} + (LW+1)'(3);
        assign req = sum[LW:2];

        always_comb begin
            case (sc_mode)
                blpc_pkg::MODE_NORMAL: ctrl_tgt[g] = req;
                blpc_pkg::MODE_DIM:    ctrl_tgt[g] = {2'b0, req[DW-1:2]};
                default:               ctrl_tgt[g] = '0;
            endcase
        end

        assign pwm_latched[g] = (r_phase == '0) ? r_target[g] : r_latched[g];
        assign lamp_hit[g]    = pwm_latched[g] > {1'b0, r_phase};
    end

    for (genvar g = LAMP_COUNT; g < 16; g++) begin : g_absent
        assign lamp_hit[g] = 1'b0;
    end

    // WAD lamps on the 8-step carrier
    always_comb begin
        wl_tgt = '0;
        wr_tgt = '0;
        for (int i = 0; i < LAMP_COUNT; i++) begin
            if (i == WAD_LEFT_POS)  wl_tgt = r_target[i];
            if (i == WAD_RIGHT_POS) wr_tgt = r_target[i];
        end
    end

    assign wphase = r_phase[QW-1:0];
    assign wl_sum = {1'b0, wl_tgt} + 8'd4;
    assign wr_sum = {1'b0, wr_tgt} + 8'd4;
    assign pwm_wl = (wphase == '0) ? wl_sum[6:3] : r_wad_l;
    assign pwm_wr = (wphase == '0) ? wr_sum[6:3] : r_wad_r;
    assign wl_on  = pwm_wl > {1'b0, wphase};
    assign wr_on  = pwm_wr > {1'b0, wphase};

    always_comb begin
        for (int i = 0; i < MW; i++) begin
            if (i == WAD_LEFT_POS || i == WAD_RIGHT_POS) begin
                pwm_mask[i] = ((i == WAD_LEFT_POS) && wl_on) || ((i == WAD_RIGHT_POS) && wr_on);
            end else begin
                pwm_mask[i] = lamp_hit[i];
            end
        end
    end

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[blpc_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (cfg_idx <= blpc_pkg::REG_WINDOW);

    always_comb begin
        unique case (cfg_idx)
            blpc_pkg::REG_STATIC:   prdata = blpc_pkg::APB_DW'(r_static);
            blpc_pkg::REG_REACTIVE: prdata = blpc_pkg::APB_DW'(r_reactive);
            blpc_pkg::REG_RELEASED: prdata = blpc_pkg::APB_DW'(r_released);
            blpc_pkg::REG_PRESSED:  prdata = blpc_pkg::APB_DW'(r_pressed);
            blpc_pkg::REG_WINDOW:   prdata = blpc_pkg::APB_DW'(r_window_cfg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_static     <= blpc_pkg::STATIC_RST;
            r_reactive   <= blpc_pkg::REACTIVE_RST;
            r_released   <= blpc_pkg::RELEASED_RST;
            r_pressed    <= blpc_pkg::PRESSED_RST;
            r_window_cfg <= blpc_pkg::WINDOW_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                blpc_pkg::REG_STATIC:   r_static     <= pwdata[LW-1:0];
                blpc_pkg::REG_REACTIVE: r_reactive   <= pwdata[0];
                blpc_pkg::REG_RELEASED: r_released   <= pwdata[LW-1:0];
                blpc_pkg::REG_PRESSED:  r_pressed    <= pwdata[LW-1:0];
                blpc_pkg::REG_WINDOW:   r_window_cfg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_target   = r_target;
        n_latched  = r_latched;
        n_host     = r_host;
        n_wad_l    = r_wad_l;
        n_wad_r    = r_wad_r;
        n_host_act = r_host_act;
        n_window   = r_window;
        n_changed  = r_changed;
        n_mask     = r_mask;
        if (accept) begin
            case (cmd)
                blpc_pkg::CMD_CTRL_TICK: begin
                    n_window  = sc_count;
                    n_mode    = sc_mode;
                    n_changed = sc_flag;
                    n_target  = ctrl_tgt;
                end
                blpc_pkg::CMD_PWM_TICK: begin
                    n_latched = pwm_latched;
                    n_wad_l   = pwm_wl;
                    n_wad_r   = pwm_wr;
                    n_mask    = pwm_mask;
                    n_phase   = r_phase + 1'b1;
                end
                blpc_pkg::CMD_HOST_WR: begin
                    for (int i = 0; i < LAMP_COUNT; i++) begin
                        if (i_item.lamp_index == blpc_pkg::INDEX_W'(i)) begin
                            n_host[i] = i_item.host_level;
                        end
                    end
                end
                blpc_pkg::CMD_HOST_ON:  n_host_act = 1'b1;
                blpc_pkg::CMD_HOST_OFF: n_host_act = 1'b0;
                blpc_pkg::CMD_SET_MODE: begin
                    if (i_item.mode_req <= blpc_pkg::MODE_OFF) begin
                        n_mode = blpc_pkg::t_mode'(i_item.mode_req);
                    end
                end
                blpc_pkg::CMD_TAKE_FLAG: n_changed = 1'b0;
                default: ;
            endcase
        end
        if (cfg_hit) begin
            n_host_act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= blpc_pkg::MODE_NORMAL;
            r_phase    <= '0;
            r_wad_l    <= '0;
            r_wad_r    <= '0;
            r_host_act <= 1'b0;
            r_window   <= '0;
            r_changed  <= 1'b0;
            r_mask     <= '0;
            for (int i = 0; i < LAMP_COUNT; i++) begin
                r_target[i]  <= '0;
                r_latched[i] <= '0;
                r_host[i]    <= '0;
            end
        end else begin
            r_mode     <= n_mode;
            r_phase    <= n_phase;
            r_target   <= n_target;
            r_latched  <= n_latched;
            r_host     <= n_host;
            r_wad_l    <= n_wad_l;
            r_wad_r    <= n_wad_r;
            r_host_act <= n_host_act;
            r_window   <= n_window;
            r_changed  <= n_changed;
            r_mask     <= n_mask;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_mask <= n_mask;
            r_out_mode <= n_mode;
            r_out_flag <= (cmd == blpc_pkg::CMD_TAKE_FLAG) ? r_changed : n_changed;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.lamp_mask  = r_out_mask;
    assign o_result.light_mode = r_out_mode;
    assign o_result.mode_flag  = r_out_flag;

    // checks
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("no result after accepted item");

    a_phase_only_on_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(accept && cmd == blpc_pkg::CMD_PWM_TICK) |=> $stable(r_phase))
        else $error("carrier phase moved without pwm tick");

    a_take_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == blpc_pkg::CMD_TAKE_FLAG) |=> !r_changed && r_out_flag == $past(r_changed))
        else $error("take flag mishandled");

    a_set_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == blpc_pkg::CMD_SET_MODE && i_item.mode_req <= blpc_pkg::MODE_OFF)
        |=> r_mode == $past(i_item.mode_req))
        else $error("set mode not applied");

endmodule

`default_nettype wire

/* tb/blpc_checker.sv */
module blpc_checker #(
    parameter int LAMP_COUNT     = 12,
    parameter int WAD_LEFT_POS   = 8,
    parameter int WAD_RIGHT_POS  = 9,
    parameter int TEST_POS       = 10,
    parameter int SERVICE_POS    = 11,
    parameter int DIRECT_TOP_POS = 7
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    blpc_in_if                               i_item_ch,
    blpc_out_if                              i_result_ch,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic                        i_pready,
    input  wire logic [blpc_pkg::APB_AW-1:0] i_paddr,
    input  wire logic [blpc_pkg::APB_DW-1:0] i_pwdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);

    localparam int MASK_W    = blpc_pkg::MASK_W;
    localparam int MODE_W    = blpc_pkg::MODE_W;
    localparam int LEVEL_W   = blpc_pkg::LEVEL_W;
    localparam int WINDOW_W  = blpc_pkg::WINDOW_W;
    localparam int PHASE_W   = blpc_pkg::PHASE_W;
    localparam int DUTY_W    = blpc_pkg::DUTY_W;
    localparam int WDUTY_W   = blpc_pkg::WDUTY_W;
    localparam int CMD_W     = blpc_pkg::CMD_W;
    localparam int INDEX_W   = blpc_pkg::INDEX_W;
    localparam int APB_AW    = blpc_pkg::APB_AW;
    localparam int WAD_STEPS = 8;

    typedef struct packed {
        logic [MASK_W-1:0] lamp_mask;
        logic [MODE_W-1:0] light_mode;
        logic              mode_flag;
    } t_lamp_report;

    logic [LEVEL_W-1:0]  static_lvl;
    logic [LEVEL_W-1:0]  released_lvl;
    logic [LEVEL_W-1:0]  pressed_lvl;
    logic                reactive_on;
    logic [WINDOW_W-1:0] window_len;

    blpc_pkg::t_mode     mode_q;
    logic [PHASE_W-1:0]  phase_q;
    logic [DUTY_W-1:0]   target_q [LAMP_COUNT];
    logic [DUTY_W-1:0]   latched_q [LAMP_COUNT];
    logic [WDUTY_W-1:0]  wad_left_q;
    logic [WDUTY_W-1:0]  wad_right_q;
    logic [LEVEL_W-1:0]  host_q [LAMP_COUNT];
    logic                host_on_q;
    logic [WINDOW_W-1:0] window_q;
    logic                flag_q;
    logic [MASK_W-1:0]   mask_q;

    t_lamp_report reports_due [$];
    int mismatches = 0;
    int checked    = 0;

    function automatic logic [DUTY_W-1:0] target_at(input int pos);
        return (pos < LAMP_COUNT) ? target_q[pos] : '0;
    endfunction

    task automatic predict_lamp_report(
        input  logic [CMD_W-1:0]   cmd,
        input  logic [MASK_W-1:0]  held,
        input  logic [MASK_W-1:0]  pressed,
        input  logic [INDEX_W-1:0] idx,
        input  logic [LEVEL_W-1:0] lvl,
        input  logic [MODE_W-1:0]  nm,
        output t_lamp_report       rep
    );
        int   raw;
        int   req;
        int   wphase;
        int   lamp_bits;
        logic down;
        case (cmd)
            blpc_pkg::CMD_CTRL_TICK: begin
                // shortcut window: test opens it, service inside it steps the mode
                if (((pressed >> TEST_POS) & 1) != 0)
                    window_q = window_len;
                if (((pressed >> SERVICE_POS) & 1) != 0 && window_q != 0) begin
                    mode_q = (mode_q == blpc_pkg::MODE_OFF) ? blpc_pkg::MODE_NORMAL
                                                            : blpc_pkg::t_mode'(mode_q + 1'b1);
                    flag_q = 1'b1;
                    window_q = '0;
                end else if (window_q != 0) begin
                    window_q = window_q - 1'b1;
                end
                for (int i = 0; i < LAMP_COUNT; i++) begin
                    down = ((held >> i) & 1) != 0;
                    if (i == WAD_LEFT_POS || i == WAD_RIGHT_POS)
                        raw = down ? pressed_lvl : released_lvl;
                    else if (host_on_q && i <= DIRECT_TOP_POS)
                        raw = host_q[i];
                    else if (reactive_on)
                        raw = down ? pressed_lvl : released_lvl;
                    else
                        raw = static_lvl;
                    req = (raw + 3) >> 2;
                    case (mode_q)
                        blpc_pkg::MODE_NORMAL: target_q[i] = DUTY_W'(req);
                        blpc_pkg::MODE_DIM:    target_q[i] = DUTY_W'(req >> 2);
                        default:               target_q[i] = '0;
                    endcase
                end
            end
            blpc_pkg::CMD_PWM_TICK: begin
                if (phase_q == 0) begin
                    for (int i = 0; i < LAMP_COUNT; i++)
                        latched_q[i] = target_q[i];
                end
                wphase = phase_q % WAD_STEPS;
                if (wphase == 0) begin
                    wad_left_q  = WDUTY_W'((target_at(WAD_LEFT_POS) + 4) >> 3);
                    wad_right_q = WDUTY_W'((target_at(WAD_RIGHT_POS) + 4) >> 3);
                end
                lamp_bits = 0;
                if (wad_left_q > wphase)
                    lamp_bits |= 1 << WAD_LEFT_POS;
                if (wad_right_q > wphase)
                    lamp_bits |= 1 << WAD_RIGHT_POS;
                for (int i = 0; i < LAMP_COUNT; i++) begin
                    if (i != WAD_LEFT_POS && i != WAD_RIGHT_POS && latched_q[i] > phase_q)
                        lamp_bits |= 1 << i;
                end
                mask_q = MASK_W'(lamp_bits);
                phase_q = phase_q + 1'b1;
            end
            blpc_pkg::CMD_HOST_WR: begin
                if (idx < LAMP_COUNT)
                    host_q[idx] = lvl;
            end
            blpc_pkg::CMD_HOST_ON:  host_on_q = 1'b1;
            blpc_pkg::CMD_HOST_OFF: host_on_q = 1'b0;
            blpc_pkg::CMD_SET_MODE: begin
                if (nm <= blpc_pkg::MODE_OFF)
                    mode_q = blpc_pkg::t_mode'(nm);
            end
            default: ;
        endcase
        rep.lamp_mask  = mask_q;
        rep.light_mode = mode_q;
        rep.mode_flag  = flag_q;
        if (cmd == blpc_pkg::CMD_TAKE_FLAG)
            flag_q = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_lamp_report exp_rep;
        t_lamp_report got_rep;
        t_lamp_report new_rep;
        logic         reg_hit;
        if (!i_rst_n) begin
            static_lvl   = blpc_pkg::STATIC_RST;
            reactive_on  = blpc_pkg::REACTIVE_RST;
            released_lvl = blpc_pkg::RELEASED_RST;
            pressed_lvl  = blpc_pkg::PRESSED_RST;
            window_len   = blpc_pkg::WINDOW_RST;
            mode_q       = blpc_pkg::MODE_NORMAL;
            phase_q      = '0;
            wad_left_q   = '0;
            wad_right_q  = '0;
            host_on_q    = 1'b0;
            window_q     = '0;
            flag_q       = 1'b0;
            mask_q       = '0;
            for (int i = 0; i < LAMP_COUNT; i++) begin
                target_q[i]  = '0;
                latched_q[i] = '0;
                host_q[i]    = '0;
            end
            reports_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_hit = 1'b1;
                case (blpc_pkg::t_reg_idx'(i_paddr[APB_AW-1:2]))
                    blpc_pkg::REG_STATIC:   static_lvl   = i_pwdata[LEVEL_W-1:0];
                    blpc_pkg::REG_REACTIVE: reactive_on  = i_pwdata[0];
                    blpc_pkg::REG_RELEASED: released_lvl = i_pwdata[LEVEL_W-1:0];
                    blpc_pkg::REG_PRESSED:  pressed_lvl  = i_pwdata[LEVEL_W-1:0];
                    blpc_pkg::REG_WINDOW:   window_len   = i_pwdata[WINDOW_W-1:0];
                    default:                reg_hit = 1'b0;
                endcase
                if (reg_hit)
                    host_on_q = 1'b0;
            end
            if (i_result_ch.valid && i_result_ch.ready) begin
                got_rep = {i_result_ch.lamp_mask, i_result_ch.light_mode,
                           i_result_ch.mode_flag};
                if (reports_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: mask %h mode %0d flag %0b",
                                 got_rep.lamp_mask, got_rep.light_mode, got_rep.mode_flag);
                    mismatches++;
                end else begin
                    exp_rep = reports_due.pop_front();
                    checked++;
                    if (got_rep !== exp_rep) begin
                        if (mismatches < 10)
                            $display({"mismatch at %0t: expected mask %h mode %0d flag %0b,",
                                      " got mask %h mode %0d flag %0b"}, $realtime,
                                     exp_rep.lamp_mask, exp_rep.light_mode,
                                     exp_rep.mode_flag, got_rep.lamp_mask,
                                     got_rep.light_mode, got_rep.mode_flag);
                        mismatches++;
                    end
                end
            end
            if (i_item_ch.valid && i_item_ch.ready) begin
                predict_lamp_report(i_item_ch.cmd, i_item_ch.buttons_held,
                                    i_item_ch.buttons_pressed, i_item_ch.lamp_index,
                                    i_item_ch.host_level, i_item_ch.mode_req, new_rep);
                reports_due.push_back(new_rep);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= reports_due.size();
        o_checked    <= checked;
    end

endmodule

/* tb/button_lamp_pwm_controller_tb.sv */
module button_lamp_pwm_controller_tb;

    localparam int LAMP_COUNT     = 12;
    localparam int WAD_LEFT_POS   = 8;
    localparam int WAD_RIGHT_POS  = 9;
    localparam int TEST_POS       = 10;
    localparam int SERVICE_POS    = 11;
    localparam int DIRECT_TOP_POS = 7;

    localparam int CMD_W    = blpc_pkg::CMD_W;
    localparam int MASK_W   = blpc_pkg::MASK_W;
    localparam int INDEX_W  = blpc_pkg::INDEX_W;
    localparam int LEVEL_W  = blpc_pkg::LEVEL_W;
    localparam int MODE_W   = blpc_pkg::MODE_W;
    localparam int WINDOW_W = blpc_pkg::WINDOW_W;
    localparam int APB_AW   = blpc_pkg::APB_AW;
    localparam int APB_DW   = blpc_pkg::APB_DW;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 105;
    localparam int PHASE_COUNT    = 6;

    localparam logic [CMD_W-1:0]  CMD_UNUSED    = 3'd7;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [MASK_W-1:0]  held;
        logic [MASK_W-1:0]  pressed;
        logic [INDEX_W-1:0] idx;
        logic [LEVEL_W-1:0] level;
        logic [MODE_W-1:0]  mode;
    } t_lamp_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_results;
    int results_checked;
    int items_sent    = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int stall_hold    = 0;
    int stall_cycle   = 0;

    blpc_in_if  item_ch ();
    blpc_out_if result_ch ();

    button_lamp_pwm_controller #(
        .LAMP_COUNT     (LAMP_COUNT),
        .WAD_LEFT_POS   (WAD_LEFT_POS),
        .WAD_RIGHT_POS  (WAD_RIGHT_POS),
        .TEST_POS       (TEST_POS),
        .SERVICE_POS    (SERVICE_POS),
        .DIRECT_TOP_POS (DIRECT_TOP_POS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    blpc_checker #(
        .LAMP_COUNT     (LAMP_COUNT),
        .WAD_LEFT_POS   (WAD_LEFT_POS),
        .WAD_RIGHT_POS  (WAD_RIGHT_POS),
        .TEST_POS       (TEST_POS),
        .SERVICE_POS    (SERVICE_POS),
        .DIRECT_TOP_POS (DIRECT_TOP_POS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_ch    (item_ch),
        .i_result_ch  (result_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_results),
        .o_checked    (results_checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stalls: always ready, random, one in four, then long random holds
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 150) % 4)
            0: result_ch.ready <= 1'b1;
            1: result_ch.ready <= 1'($urandom_range(0, 1));
            2: result_ch.ready <= (stall_cycle % 4 == 0);
            default: begin
                if (stall_hold > 0) begin
                    stall_hold <= stall_hold - 1;
                    result_ch.ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_hold <= $urandom_range(3, 11);
                    result_ch.ready <= 1'b0;
                end else begin
                    result_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic t_lamp_item pack_item(
        input logic [CMD_W-1:0]   cmd,
        input logic [MASK_W-1:0]  held,
        input logic [MASK_W-1:0]  pressed,
        input logic [INDEX_W-1:0] idx,
        input logic [LEVEL_W-1:0] level,
        input logic [MODE_W-1:0]  mode
    );
        return {cmd, held, pressed, idx, level, mode};
    endfunction

    function automatic t_lamp_item random_item();
        t_lamp_item it;
        int         pick;
        pick       = $urandom_range(0, 99);
        it.held    = MASK_W'($urandom);
        it.pressed = MASK_W'($urandom);
        it.idx     = INDEX_W'($urandom);
        it.level   = LEVEL_W'($urandom);
        it.mode    = MODE_W'($urandom);
        if (pick < 44)
            it.cmd = blpc_pkg::CMD_PWM_TICK;
        else if (pick < 68)
            it.cmd = blpc_pkg::CMD_CTRL_TICK;
        else if (pick < 77)
            it.cmd = blpc_pkg::CMD_HOST_WR;
        else if (pick < 82)
            it.cmd = blpc_pkg::CMD_HOST_ON;
        else if (pick < 85)
            it.cmd = blpc_pkg::CMD_HOST_OFF;
        else if (pick < 91)
            it.cmd = blpc_pkg::CMD_SET_MODE;
        else if (pick < 97)
            it.cmd = blpc_pkg::CMD_TAKE_FLAG;
        else
            it.cmd = CMD_UNUSED;
        // keep stray shortcut presses rare
        if (it.cmd == blpc_pkg::CMD_CTRL_TICK && $urandom_range(0, 9) != 0) begin
            it.pressed[TEST_POS]    = 1'b0;
            it.pressed[SERVICE_POS] = 1'b0;
        end
        return it;
    endfunction

    task automatic send_item(input t_lamp_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item_ch.valid           <= 1'b1;
        item_ch.cmd             <= it.cmd;
        item_ch.buttons_held    <= it.held;
        item_ch.buttons_pressed <= it.pressed;
        item_ch.lamp_index      <= it.idx;
        item_ch.host_level      <= it.level;
        item_ch.mode_req        <= it.mode;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic write_reg(input blpc_pkg::t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        t_lamp_item          it;
        int                  n;
        int                  hops;
        logic [LEVEL_W-1:0]  set_static;
        logic [LEVEL_W-1:0]  set_released;
        logic [LEVEL_W-1:0]  set_pressed;
        logic                set_reactive;
        logic [WINDOW_W-1:0] set_window;

        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        item_ch.valid           = 1'b0;
        item_ch.cmd             = '0;
        item_ch.buttons_held    = '0;
        item_ch.buttons_pressed = '0;
        item_ch.lamp_index      = '0;
        item_ch.host_level      = '0;
        item_ch.mode_req        = '0;
        result_ch.ready         = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items under reset settings
        send_item(pack_item(blpc_pkg::CMD_TAKE_FLAG, '0, '0, '0, '0, '0));
        send_item(pack_item(CMD_UNUSED, 12'hfff, 12'hfff, 4'd15, 8'hff, MODE_RESERVED));
        send_item(pack_item(blpc_pkg::CMD_HOST_WR, '0, '0, 4'd0, 8'd255, '0));
        send_item(pack_item(blpc_pkg::CMD_HOST_WR, '0, '0, 4'd7, 8'd1, '0));
        send_item(pack_item(blpc_pkg::CMD_HOST_WR, '0, '0, 4'd3, 8'd128, '0));
        send_item(pack_item(blpc_pkg::CMD_HOST_WR, '0, '0, 4'd15, 8'd255, '0));
        send_item(pack_item(blpc_pkg::CMD_HOST_WR, '0, '0, 4'd12, 8'd255, '0));
        send_item(pack_item(blpc_pkg::CMD_HOST_ON, '0, '0, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_CTRL_TICK, 12'hfff, '0, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_PWM_TICK, '0, '0, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_PWM_TICK, '0, '0, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_SET_MODE, '0, '0, '0, '0, blpc_pkg::MODE_DIM));
        send_item(pack_item(blpc_pkg::CMD_SET_MODE, '0, '0, '0, '0, MODE_RESERVED));
        send_item(pack_item(blpc_pkg::CMD_CTRL_TICK, '0, '0, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_SET_MODE, '0, '0, '0, '0, blpc_pkg::MODE_OFF));
        send_item(pack_item(blpc_pkg::CMD_CTRL_TICK, 12'hfff, '0, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_SET_MODE, '0, '0, '0, '0, blpc_pkg::MODE_NORMAL));
        send_item(pack_item(blpc_pkg::CMD_HOST_OFF, '0, '0, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_CTRL_TICK, '0, MASK_W'(1 << TEST_POS), '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_CTRL_TICK, '0, MASK_W'(1 << SERVICE_POS),
                            '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_TAKE_FLAG, '0, '0, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_TAKE_FLAG, '0, '0, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_CTRL_TICK, 12'hfff, 12'hfff, '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_CTRL_TICK, '0, MASK_W'(1 << SERVICE_POS),
                            '0, '0, '0));
        send_item(pack_item(blpc_pkg::CMD_PWM_TICK, '0, '0, '0, '0, '0));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    set_static = blpc_pkg::STATIC_RST;
                    set_reactive = blpc_pkg::REACTIVE_RST;
                    set_released = blpc_pkg::RELEASED_RST;
                    set_pressed = blpc_pkg::PRESSED_RST;
                    set_window = blpc_pkg::WINDOW_RST;
                end
                1: begin
                    set_static = '0; set_reactive = 1'b0; set_released = '0;
                    set_pressed = '0; set_window = 16'd1;
                end
                2: begin
                    set_static = 8'hff; set_reactive = 1'b0; set_released = 8'hff;
                    set_pressed = 8'hff; set_window = 16'd2;
                end
                3: begin
                    set_static = 8'hff; set_reactive = 1'b1; set_released = '0;
                    set_pressed = 8'hff; set_window = 16'hffff;
                end
                4: begin
                    set_static = LEVEL_W'($urandom); set_reactive = 1'b1;
                    set_released = LEVEL_W'($urandom); set_pressed = LEVEL_W'($urandom);
                    set_window = 16'd3;
                end
                default: begin
                    set_static = LEVEL_W'($urandom); set_reactive = 1'($urandom);
                    set_released = LEVEL_W'($urandom); set_pressed = LEVEL_W'($urandom);
                    set_window = WINDOW_W'($urandom_range(1, 6));
                end
            endcase
            drain_results();
            write_reg(blpc_pkg::REG_STATIC, APB_DW'(set_static));
            write_reg(blpc_pkg::REG_REACTIVE, APB_DW'(set_reactive));
            write_reg(blpc_pkg::REG_RELEASED, APB_DW'(set_released));
            write_reg(blpc_pkg::REG_PRESSED, APB_DW'(set_pressed));
            write_reg(blpc_pkg::REG_WINDOW, APB_DW'(set_window));
            settings_used++;

            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 10) begin
                    // test press, up to three random items, service press, then collect the flag
                    it = random_item();
                    it.cmd = blpc_pkg::CMD_CTRL_TICK;
                    it.pressed[TEST_POS]    = 1'b1;
                    it.pressed[SERVICE_POS] = 1'b0;
                    send_item(it);
                    hops = $urandom_range(0, 3);
                    repeat (hops) send_item(random_item());
                    it = random_item();
                    it.cmd = blpc_pkg::CMD_CTRL_TICK;
                    it.pressed[TEST_POS]    = ($urandom_range(0, 3) == 0);
                    it.pressed[SERVICE_POS] = 1'b1;
                    send_item(it);
                    it = random_item();
                    it.cmd = blpc_pkg::CMD_TAKE_FLAG;
                    send_item(it);
                    n += hops + 3;
                end else begin
                    send_item(random_item());
                    n++;
                end
            end
        end

        drain_results();
        $display("Run covered %0d command items across %0d register settings plus reset values.",
                 items_sent, settings_used);
        $display("%0d lamp reports compared, %0d of them wrong or unexpected.",
                 results_checked, fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
